### rtl/avsc_pkg.sv
// Shared types, codes and offset tables of the audio volume / source controller.
package avsc_pkg;

	// Event kinds on the input tuser field
	localparam logic [2:0] FUNC_TURN_CW  = 3'd0;
	localparam logic [2:0] FUNC_TURN_CCW = 3'd1;
	localparam logic [2:0] FUNC_BUTTON   = 3'd2;
	localparam logic [2:0] FUNC_REMOTE   = 3'd3;
	localparam logic [2:0] FUNC_TICK     = 3'd4;
	localparam logic [2:0] FUNC_PFAIL    = 3'd5;

	// Operating modes as reported on the output
	localparam logic [1:0] MODE_RUN    = 2'd0;
	localparam logic [1:0] MODE_SELECT = 2'd1;
	localparam logic [1:0] MODE_OFF    = 2'd2;

	// Input sources
	localparam logic [2:0] INPUT_PHONO = 3'd1;
	localparam logic [2:0] INPUT_MEDIA = 3'd2;
	localparam logic [2:0] INPUT_CD    = 3'd3;
	localparam logic [2:0] INPUT_TUNER = 3'd4;

	// Remote command numbers
	localparam logic [5:0] RC_PHONO    = 6'd1;
	localparam logic [5:0] RC_TUNER    = 6'd3;
	localparam logic [5:0] RC_CD       = 6'd7;
	localparam logic [5:0] RC_MEDIA    = 6'd8;
	localparam logic [5:0] RC_MUTE     = 6'd13;
	localparam logic [5:0] RC_VOL_UP   = 6'd16;
	localparam logic [5:0] RC_VOL_DN   = 6'd17;
	localparam logic [5:0] RC_BAL_UP   = 6'd32;
	localparam logic [5:0] RC_BAL_DN   = 6'd33;
	localparam logic [5:0] RC_AUX_CD   = 6'd53;
	localparam logic [5:0] RC_DISPLAY  = 6'd59;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAX_VOLUME  = 2'd0;
	localparam logic [1:0] CFG_SEL_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_MAIN_ADDR   = 2'd2;
	localparam logic [1:0] CFG_AUX_ADDR    = 2'd3;

	// Reset values of configuration and state
	localparam logic [7:0]  RST_MAX_VOLUME  = 8'd234;
	localparam logic [15:0] RST_SEL_TIMEOUT = 16'd5000;
	localparam logic [4:0]  RST_MAIN_ADDR   = 5'h10;
	localparam logic [4:0]  RST_AUX_ADDR    = 5'h14;
	localparam logic [3:0]  BAL_CENTER      = 4'd5;
	localparam logic [3:0]  BAL_MAX         = 4'd10;
	localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

	// Depth of the command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Classified operation handed from front to back
	typedef enum logic [4:0] {
		OP_NONE,
		OP_TURN_CW,
		OP_TURN_CCW,
		OP_BUTTON,
		OP_TICK,
		OP_PFAIL,
		OP_REMOTE_IGNORE,
		OP_PICK_PHONO,
		OP_PICK_MEDIA,
		OP_PICK_CD,
		OP_PICK_TUNER,
		OP_MUTE_TOGGLE,
		OP_VOL_UP,
		OP_VOL_DN,
		OP_BAL_UP,
		OP_BAL_DN,
		OP_DISPLAY
	} op_t;

	typedef struct packed {
		op_t  op;
		logic remote;  // item was a remote frame: toggle bit is recorded
		logic toggle;
	} cmd_t;

	typedef struct packed {
		logic [7:0] left_level;
		logic [7:0] right_level;
		logic [7:0] volume_step;
		logic [3:0] balance_step;
		logic [2:0] input_select;
		logic [2:0] previous_input;
		logic       muted;
		logic       backlight_on;
		logic [1:0] mode;
	} result_t;

	// Left channel offset per balance index; indexes past the last table entry read as zero
	function automatic logic [7:0] left_offset(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0:    v = 8'd21;
			4'd1:    v = 8'd20;
			4'd2:    v = 8'd19;
			4'd3:    v = 8'd18;
			4'd4:    v = 8'd16;
			4'd5:    v = 8'd15;
			4'd6:    v = 8'd13;
			4'd7:    v = 8'd11;
			4'd8:    v = 8'd8;
			4'd9:    v = 8'd5;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] right_offset(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0:    v = 8'd0;
			4'd1:    v = 8'd5;
			4'd2:    v = 8'd8;
			4'd3:    v = 8'd11;
			4'd4:    v = 8'd13;
			4'd5:    v = 8'd15;
			4'd6:    v = 8'd16;
			4'd7:    v = 8'd18;
			4'd8:    v = 8'd19;
			4'd9:    v = 8'd20;
			default: v = 8'd21;
		endcase
		return v;
	endfunction

endpackage

### rtl/avsc_front.sv
// Front stage: accepts events, decodes remote frames into operations, registers them.
module avsc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic               remote_toggle,
	input  logic [4:0]         remote_address,
	input  logic [5:0]         remote_command,
	input  logic [4:0]         main_remote_address,
	input  logic [4:0]         aux_remote_address,
	output logic               out_valid,
	input  logic               out_ready,
	output avsc_pkg::cmd_t     out_cmd
);

	avsc_pkg::op_t  op;
	logic           valid_s1;
	avsc_pkg::cmd_t cmd_s1;

	// Decode event kind and remote command set
	always_comb begin
		op = avsc_pkg::OP_NONE;
		case (func)
			avsc_pkg::FUNC_TURN_CW:  op = avsc_pkg::OP_TURN_CW;
			avsc_pkg::FUNC_TURN_CCW: op = avsc_pkg::OP_TURN_CCW;
			avsc_pkg::FUNC_BUTTON:   op = avsc_pkg::OP_BUTTON;
			avsc_pkg::FUNC_TICK:     op = avsc_pkg::OP_TICK;
			avsc_pkg::FUNC_PFAIL:    op = avsc_pkg::OP_PFAIL;
			avsc_pkg::FUNC_REMOTE: begin
				op = avsc_pkg::OP_REMOTE_IGNORE;
				// main address wins when both addresses match
				if (remote_address == main_remote_address) begin
					case (remote_command)
						avsc_pkg::RC_PHONO:   op = avsc_pkg::OP_PICK_PHONO;
						avsc_pkg::RC_TUNER:   op = avsc_pkg::OP_PICK_TUNER;
						avsc_pkg::RC_CD:      op = avsc_pkg::OP_PICK_CD;
						avsc_pkg::RC_MEDIA:   op = avsc_pkg::OP_PICK_MEDIA;
						avsc_pkg::RC_MUTE:    op = avsc_pkg::OP_MUTE_TOGGLE;
						avsc_pkg::RC_VOL_UP:  op = avsc_pkg::OP_VOL_UP;
						avsc_pkg::RC_VOL_DN:  op = avsc_pkg::OP_VOL_DN;
						avsc_pkg::RC_BAL_UP:  op = avsc_pkg::OP_BAL_UP;
						avsc_pkg::RC_BAL_DN:  op = avsc_pkg::OP_BAL_DN;
						avsc_pkg::RC_DISPLAY: op = avsc_pkg::OP_DISPLAY;
						default:              op = avsc_pkg::OP_REMOTE_IGNORE;
					endcase
				end else if (remote_address == aux_remote_address &&
					remote_command == avsc_pkg::RC_AUX_CD) begin
					op = avsc_pkg::OP_PICK_CD;
				end
			end
			default: op = avsc_pkg::OP_NONE;
		endcase
	end

	assign in_ready = !valid_s1 || out_ready;

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.op     <= op;
			cmd_s1.remote <= (func == avsc_pkg::FUNC_REMOTE);
			cmd_s1.toggle <= remote_toggle;
		end
	end

	assign out_valid = valid_s1;
	assign out_cmd   = cmd_s1;

endmodule

### rtl/avsc_queue.sv
// Short command queue decoupling the front decoder from the state update.
module avsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  avsc_pkg::cmd_t in_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output avsc_pkg::cmd_t out_cmd
);

	avsc_pkg::cmd_t                      mem_q [avsc_pkg::QDEPTH];
	logic [avsc_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [avsc_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [avsc_pkg::QCNT_W-1:0]         count_q;
	logic                                push;
	logic                                pop;

	assign in_ready  = (count_q != avsc_pkg::QCNT_W'(avsc_pkg::QDEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == avsc_pkg::QPTR_W'(avsc_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == avsc_pkg::QPTR_W'(avsc_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

### rtl/avsc_back.sv
// Back stage: applies operations to the preamp state and registers one result per item.
module avsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  avsc_pkg::cmd_t    in_cmd,
	input  logic [7:0]        max_volume,
	input  logic [15:0]       select_timeout_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output avsc_pkg::result_t out_result
);

	logic [1:0]  mode_q,   mode_n;
	logic [7:0]  vol_q,    vol_n;
	logic [3:0]  bal_q,    bal_n;
	logic [2:0]  in_q,     in_n;
	logic [2:0]  prev_q,   prev_n;
	logic        muted_q,  muted_n;
	logic        bl_q,     bl_n;
	logic        last_q,   last_n;
	logic [15:0] idle_q,   idle_n;
	logic        changed;
	logic        take;
	logic        res_valid_q;
	avsc_pkg::result_t res_q;

	assign in_ready = !res_valid_q || out_ready;
	assign take     = in_valid && in_ready;
	assign changed  = (in_cmd.toggle != last_q);

	// Next state for the operation at the head of the queue
	always_comb begin
		mode_n  = mode_q;
		vol_n   = vol_q;
		bal_n   = bal_q;
		in_n    = in_q;
		prev_n  = prev_q;
		muted_n = muted_q;
		bl_n    = bl_q;
		last_n  = last_q;
		idle_n  = idle_q;
		case (in_cmd.op)
			avsc_pkg::OP_TURN_CW: begin
				if (mode_q == avsc_pkg::MODE_RUN) begin
					if (vol_q < max_volume) begin
						vol_n = vol_q + 8'd1;
						muted_n = 1'b0;
						bl_n = 1'b1;
					end
				end else if (mode_q == avsc_pkg::MODE_SELECT) begin
					prev_n = in_q;
					idle_n = '0;
					in_n = (in_q < avsc_pkg::INPUT_TUNER) ? in_q + 3'd1 : avsc_pkg::INPUT_PHONO;
				end
			end
			avsc_pkg::OP_TURN_CCW: begin
				if (mode_q == avsc_pkg::MODE_RUN) begin
					if (vol_q != 8'd0) begin
						vol_n = vol_q - 8'd1;
						muted_n = 1'b0;
						bl_n = 1'b1;
					end
				end else if (mode_q == avsc_pkg::MODE_SELECT) begin
					prev_n = in_q;
					idle_n = '0;
					in_n = (in_q > avsc_pkg::INPUT_PHONO) ? in_q - 3'd1 : avsc_pkg::INPUT_TUNER;
				end
			end
			avsc_pkg::OP_BUTTON: begin
				if (mode_q == avsc_pkg::MODE_RUN) begin
					mode_n = avsc_pkg::MODE_SELECT;
					idle_n = '0;
				end
			end
			avsc_pkg::OP_TICK: begin
				if (idle_q != avsc_pkg::IDLE_MAX) begin
					idle_n = idle_q + 16'd1;
				end
			end
			avsc_pkg::OP_PFAIL: begin
				bl_n = 1'b0;
				muted_n = 1'b1;
				mode_n = avsc_pkg::MODE_OFF;
			end
			avsc_pkg::OP_PICK_PHONO: begin
				if (changed) begin
					prev_n = in_q;
					in_n = avsc_pkg::INPUT_PHONO;
				end
			end
			avsc_pkg::OP_PICK_MEDIA: begin
				if (changed) begin
					prev_n = in_q;
					in_n = avsc_pkg::INPUT_MEDIA;
				end
			end
			avsc_pkg::OP_PICK_CD: begin
				if (changed) begin
					prev_n = in_q;
					in_n = avsc_pkg::INPUT_CD;
				end
			end
			avsc_pkg::OP_PICK_TUNER: begin
				if (changed) begin
					prev_n = in_q;
					in_n = avsc_pkg::INPUT_TUNER;
				end
			end
			avsc_pkg::OP_MUTE_TOGGLE: begin
				if (changed) begin
					if (muted_q) begin
						muted_n = 1'b0;
						bl_n = 1'b1;
					end else begin
						muted_n = 1'b1;
					end
				end
			end
			// remote volume steps act on every frame
			avsc_pkg::OP_VOL_UP: begin
				if (vol_q < max_volume) begin
					vol_n = vol_q + 8'd1;
					muted_n = 1'b0;
					bl_n = 1'b1;
				end
			end
			avsc_pkg::OP_VOL_DN: begin
				if (vol_q != 8'd0) begin
					vol_n = vol_q - 8'd1;
					muted_n = 1'b0;
					bl_n = 1'b1;
				end
			end
			avsc_pkg::OP_BAL_UP: begin
				if (changed && bal_q < avsc_pkg::BAL_MAX) begin
					bal_n = bal_q + 4'd1;
				end
			end
			avsc_pkg::OP_BAL_DN: begin
				if (changed && bal_q != 4'd0) begin
					bal_n = bal_q - 4'd1;
				end
			end
			avsc_pkg::OP_DISPLAY: begin
				if (changed) begin
					if (bl_q) begin
						bl_n = 1'b0;
						muted_n = 1'b1;
					end else begin
						bl_n = 1'b1;
						muted_n = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		if (in_cmd.remote) begin
			last_n = in_cmd.toggle;
		end
		// select timeout is checked after every item, in any mode
		if (idle_n > select_timeout_ms) begin
			mode_n = avsc_pkg::MODE_RUN;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= avsc_pkg::MODE_RUN;
			vol_q   <= 8'd0;
			bal_q   <= avsc_pkg::BAL_CENTER;
			in_q    <= avsc_pkg::INPUT_PHONO;
			prev_q  <= avsc_pkg::INPUT_PHONO;
			muted_q <= 1'b0;
			bl_q    <= 1'b1;
			last_q  <= 1'b0;
			idle_q  <= 16'd0;
		end else if (take) begin
			mode_q  <= mode_n;
			vol_q   <= vol_n;
			bal_q   <= bal_n;
			in_q    <= in_n;
			prev_q  <= prev_n;
			muted_q <= muted_n;
			bl_q    <= bl_n;
			last_q  <= last_n;
			idle_q  <= idle_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_ready) begin
			res_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.left_level     <= vol_n + avsc_pkg::left_offset(bal_n);
			res_q.right_level    <= vol_n + avsc_pkg::right_offset(bal_n);
			res_q.volume_step    <= vol_n;
			res_q.balance_step   <= bal_n;
			res_q.input_select   <= in_n;
			res_q.previous_input <= prev_n;
			res_q.muted          <= muted_n;
			res_q.backlight_on   <= bl_n;
			res_q.mode           <= mode_n;
		end
	end

	assign out_valid  = res_valid_q;
	assign out_result = res_q;

endmodule

### rtl/audio_volume_source_controller_top.sv
// Top level of the audio volume / source controller: configuration registers and stage wiring.
//
// Takes one control event per item (encoder turn, button, remote frame, ms tick, power
// fail) and returns one result item per event with the preamp state after that event:
// both attenuator levels, volume, balance, input, previous input, mute, backlight, mode.
// Sustained rate is one item per clock cycle while the master side does not stall; the
// state update in the back stage is combinational ahead of the result register. An item's
// result passes the decode register, the two-entry command queue and the result register
// on its way to the master side, and is held there while the master side stalls; the queue
// lets the input side keep taking items meanwhile.
// Configuration writes are always accepted and take effect on the next cycle; write them
// only while no items are in flight.
module audio_volume_source_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	// event input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [0] remote_toggle, [5:1] remote_address,
	                               // [11:6] remote_command, [15:12] zero
	input  logic [2:0]  s_tuser,   // [2:0] func
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] left_level, [15:8] right_level,
	                               // [23:16] volume_step, [27:24] balance_step,
	                               // [30:28] input_select, [33:31] previous_input,
	                               // [34] muted, [35] backlight_on, [37:36] mode,
	                               // [39:38] zero
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]        max_volume_q;
	logic [15:0]       sel_timeout_q;
	logic [4:0]        main_addr_q;
	logic [4:0]        aux_addr_q;
	logic              f_valid;
	logic              f_ready;
	avsc_pkg::cmd_t    f_cmd;
	logic              q_valid;
	logic              q_ready;
	avsc_pkg::cmd_t    q_cmd;
	avsc_pkg::result_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_volume_q  <= avsc_pkg::RST_MAX_VOLUME;
			sel_timeout_q <= avsc_pkg::RST_SEL_TIMEOUT;
			main_addr_q   <= avsc_pkg::RST_MAIN_ADDR;
			aux_addr_q    <= avsc_pkg::RST_AUX_ADDR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				avsc_pkg::CFG_MAX_VOLUME:  max_volume_q  <= cfg_data[7:0];
				avsc_pkg::CFG_SEL_TIMEOUT: sel_timeout_q <= cfg_data;
				avsc_pkg::CFG_MAIN_ADDR:   main_addr_q   <= cfg_data[4:0];
				avsc_pkg::CFG_AUX_ADDR:    aux_addr_q    <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	avsc_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (s_tvalid),
		.in_ready            (s_tready),
		.func                (s_tuser),
		.remote_toggle       (s_tdata[0]),
		.remote_address      (s_tdata[5:1]),
		.remote_command      (s_tdata[11:6]),
		.main_remote_address (main_addr_q),
		.aux_remote_address  (aux_addr_q),
		.out_valid           (f_valid),
		.out_ready           (f_ready),
		.out_cmd             (f_cmd)
	);

	avsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_cmd    (f_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	avsc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (q_valid),
		.in_ready          (q_ready),
		.in_cmd            (q_cmd),
		.max_volume        (max_volume_q),
		.select_timeout_ms (sel_timeout_q),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_result        (res)
	);

	// Pack the result, first field lowest
	assign m_tdata = {2'b00, res.mode, res.backlight_on, res.muted, res.previous_input,
		res.input_select, res.balance_step, res.volume_step, res.right_level,
		res.left_level};

endmodule
